>>> hw/rtl/gens_pkg.sv
// gens_pkg: widths, types and normalized kernel weights for the edge-aware smoother
// no dependencies; imported by gaussian_edge_normalized_smoother
package gens_pkg;

  localparam int BinWidth  = 24;
  localparam int WeightW   = 19;
  localparam int FracBits  = 18;
  localparam int NumTaps   = 5;
  localparam int ProdW     = BinWidth + WeightW;
  localparam int SumW      = ProdW + 3;
  localparam int RoundW    = SumW - FracBits;

  typedef logic [BinWidth-1:0] bin_t;
  typedef logic [WeightW-1:0]  weight_t;
  typedef logic [ProdW-1:0]    prod_t;
  typedef logic [1:0]          drop_t;
  typedef logic [2:0]          tap_idx_t;

  // unsigned q1.18 weight of tap t with dl taps dropped on the left, dr on the right
  function automatic weight_t tap_weight(drop_t dl, drop_t dr, tap_idx_t t);
    logic [NumTaps-1:0][WeightW-1:0] row;
    weight_t w;
    unique case ({dl, dr})
      4'b0000: row = {19'd23756, 19'd63541, 19'd87550, 19'd63541, 19'd23756};
      4'b0100: row = {19'd26123, 19'd69873, 19'd96275, 19'd69873, 19'd0};
      4'b0001: row = {19'd0, 19'd69873, 19'd96275, 19'd69873, 19'd26123};
      4'b1000: row = {19'd35616, 19'd95266, 19'd131262, 19'd0, 19'd0};
      4'b0010: row = {19'd0, 19'd0, 19'd131262, 19'd95266, 19'd35616};
      4'b0101: row = {19'd0, 19'd77607, 19'd106931, 19'd77607, 19'd0};
      4'b1001: row = {19'd0, 19'd110244, 19'd151900, 19'd0, 19'd0};
      4'b0110: row = {19'd0, 19'd0, 19'd151900, 19'd110244, 19'd0};
      4'b1010: row = {19'd0, 19'd0, 19'd262144, 19'd0, 19'd0};
      default: row = '0;
    endcase
    if (t < tap_idx_t'(NumTaps)) begin
      w = row[t];
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/gaussian_edge_normalized_smoother.sv
// gaussian_edge_normalized_smoother: five-tap gaussian smoothing of histogram bins,
// edge taps dropped and weights renormalized; uses gens_pkg
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   bin_value, is_last
//   output   out        out_valid / out_ready smoothed_value, last_out
//
// one bin accepted per cycle while in_ready is high; a last bin that flushes n pending results
// (up to three) holds the job register until all n have fired, and in_ready stays low until then
// a bin's first result passes through the job register, the product register,
// then the output register (sum, round, saturate)
// rst clears the window, the bin count and all valid flags
// product and output registers advance into free slots, so input keeps flowing while a result
// waits on out_ready only as long as an empty register lies ahead of the job register
module gaussian_edge_normalized_smoother (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gens_pkg::bin_t bin_value,
  input  logic           is_last,
  output logic           out_valid,
  input  logic           out_ready,
  output gens_pkg::bin_t smoothed_value,
  output logic           last_out
);
  import gens_pkg::*;

  localparam logic [RoundW-1:0] SatLimit = RoundW'({BinWidth{1'b1}});

  bin_t       win [4];
  logic [2:0] seen;

  bin_t       job_tap [NumTaps];
  logic [2:0] job_seen;
  logic       job_last;
  logic [1:0] job_d;
  logic       job_valid;

  prod_t      prod [NumTaps];
  prod_t      prod_next [NumTaps];
  logic       prod_last;
  logic       prod_valid;

  logic       out_free;
  logic       prod_free;
  logic       job_fire;
  logic       job_final;
  logic       in_fire;
  logic       in_emits;
  logic [1:0] d_start;
  logic [2:0] job_k;
  drop_t      drop_l;
  drop_t      drop_r;

  logic [SumW-1:0]   sum;
  logic [RoundW-1:0] rounded;
  bin_t              result;

  assign out_free  = !out_valid || out_ready;
  assign prod_free = !prod_valid || out_free;
  assign job_fire  = job_valid && prod_free;
  assign job_final = !job_last || (job_d == 2'd0);
  assign in_ready  = !job_valid || (job_fire && job_final);
  assign in_fire   = in_valid && in_ready;
  assign in_emits  = is_last || (seen >= 3'd2);

  always_comb begin
    if (!is_last || seen >= 3'd2) begin
      d_start = 2'd2;
    end else if (seen == 3'd1) begin
      d_start = 2'd1;
    end else begin
      d_start = 2'd0;
    end
  end

  // pending bin index and dropped taps on each side
  always_comb begin
    job_k  = job_seen - {1'b0, job_d};
    drop_l = (job_k < 3'd2) ? drop_t'(3'd2 - job_k) : 2'd0;
    drop_r = job_last ? (2'd2 - job_d) : 2'd0;
  end

  always_comb begin
    tap_idx_t idx;
    bin_t     tap;
    for (int t = 0; t < NumTaps; t++) begin
      idx = 3'd2 - {1'b0, job_d} + tap_idx_t'(t);
      tap = (idx < tap_idx_t'(NumTaps)) ? job_tap[idx] : '0;
      prod_next[t] = ProdW'(tap) * ProdW'(tap_weight(drop_l, drop_r, tap_idx_t'(t)));
    end
  end

  always_comb begin
    sum = SumW'(1) << (FracBits - 1);
    for (int t = 0; t < NumTaps; t++) begin
      sum = sum + SumW'(prod[t]);
    end
    rounded = sum[SumW-1:FracBits];
    result  = (rounded > SatLimit) ? {BinWidth{1'b1}} : rounded[BinWidth-1:0];
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        win[i] <= '0;
      end
      seen       <= '0;
      job_valid  <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        if (is_last) begin
          for (int i = 0; i < 4; i++) begin
            win[i] <= '0;
          end
          seen <= '0;
        end else begin
          win[3] <= win[2];
          win[2] <= win[1];
          win[1] <= win[0];
          win[0] <= bin_value;
          if (seen < 3'd4) begin
            seen <= seen + 3'd1;
          end
        end
      end
      if (in_fire) begin
        job_valid <= in_emits;
      end else if (job_fire && job_final) begin
        job_valid <= 1'b0;
      end
      if (prod_free) begin
        prod_valid <= job_fire;
      end
      if (out_free) begin
        out_valid <= prod_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_tap[0] <= win[3];
      job_tap[1] <= win[2];
      job_tap[2] <= win[1];
      job_tap[3] <= win[0];
      job_tap[4] <= bin_value;
      job_seen   <= seen;
      job_last   <= is_last;
      job_d      <= d_start;
    end else if (job_fire) begin
      job_d <= job_d - 2'd1;
    end
    if (job_fire) begin
      for (int t = 0; t < NumTaps; t++) begin
        prod[t] <= prod_next[t];
      end
      prod_last <= job_last && (job_d == 2'd0);
    end
    if (out_free && prod_valid) begin
      smoothed_value <= result;
      last_out       <= prod_last;
    end
  end

endmodule
